>>> rtl/q4k_superblock_dequantizer_unit_macros.svh
// Assertion helpers used by the checker file.
`ifndef Q4K_SUPERBLOCK_DEQUANTIZER_UNIT_MACROS_SVH
`define Q4K_SUPERBLOCK_DEQUANTIZER_UNIT_MACROS_SVH

// Implication checked outside reset.
`define Q4K_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// Condition that must never hold outside reset.
`define Q4K_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");

// Next-cycle implication checked with no reset gating.
`define Q4K_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/q4k_pkg.sv
// ----------------------------------------------------------------------------
// q4k_pkg
// Shared types and constants of the Q4_K super-block dequantizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package q4k_pkg;

  localparam int BlockValues = 256;
  localparam int ChunkLanes  = 32;
  localparam int PairCount   = 8;
  localparam logic [3:0]  NIBBLE_MASK = 4'hF;
  localparam logic [31:0] CANON_NAN   = 32'h7FC0_0000;

  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_DATA   = 1'b1;

  // operands handed to one dequant lane
  typedef struct packed {
    logic [15:0] d;
    logic [15:0] dmin;
    logic [5:0]  sc;
    logic [5:0]  m;
    logic [3:0]  q;
  } lane_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] bits;
  } lane_res_t;

endpackage

>>> rtl/q4k_superblock_dequantizer_unit.sv
// ----------------------------------------------------------------------------
// q4k_superblock_dequantizer_unit
// Q4_K super-block dequantizer: two lanes decode the low and high nibble of
// each quant byte, a merge stage returns their results in element order.
// ----------------------------------------------------------------------------
//  channel | ports                        | carries
//  input   | in_valid / in_ready          | header or one quant byte
//  output  | out_valid / out_ready        | one float value, index, last flag
//
//  A header is accepted and stored. A data byte with emitted elements is accepted,
//  passes through the lane pipeline, then shows its results one at a time; no new
//  item is taken before the last has left. A byte with nothing to emit is only accepted.
//  rst_n clears control, header and scale state; output stalls hold the lane results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module q4k_superblock_dequantizer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [15:0] in_half_scale,
  input  logic [15:0] in_half_min,
  input  logic [63:0] in_scale_bytes_low,
  input  logic [31:0] in_scale_bytes_high,
  input  logic [8:0]  in_valid_count,
  input  logic [7:0]  in_quant_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value_bits,
  output logic [7:0]  out_element_index,
  output logic        out_last_of_item
);
  import q4k_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_OUT} state_t;

  state_t      state_r;
  logic [15:0] d_r, dmin_r;
  logic [5:0]  sc_r [PairCount];
  logic [5:0]  mn_r [PairCount];
  logic [8:0]  limit_r;
  logic [7:0]  pos_r;
  logic [1:0]  emit_r;
  logic        sel_r;
  logic [7:0]  idx0_r, idx1_r;
  logic [31:0] res0_r, res1_r;

  logic [7:0]  sb [12];
  logic [7:0]  idx0, idx1;
  logic        e0, e1, acc, start;
  lane_req_t   req0, req1;
  lane_res_t   res0, res1;

  always_comb begin
    for (int k = 0; k < 8; k++) sb[k] = in_scale_bytes_low[8*k +: 8];
    for (int k = 0; k < 4; k++) sb[8+k] = in_scale_bytes_high[8*k +: 8];
    idx0  = {pos_r[6:5], 1'b0, pos_r[4:0]};
    idx1  = {pos_r[6:5], 1'b1, pos_r[4:0]};
    e0    = {1'b0, idx0} < limit_r;
    e1    = {1'b0, idx1} < limit_r;
    acc   = in_valid && in_ready;
    start = acc && (in_operation == OP_DATA) && !pos_r[7] && (e0 || e1);
    req0  = '{d: d_r, dmin: dmin_r, sc: sc_r[0], m: mn_r[0],
              q: in_quant_byte[3:0] & NIBBLE_MASK};
    req1  = '{d: d_r, dmin: dmin_r, sc: sc_r[1], m: mn_r[1],
              q: in_quant_byte[7:4] & NIBBLE_MASK};
  end

  q4k_lane u_lane0 (.clk(clk), .rst_n(rst_n), .start(start), .req(req0), .res(res0));
  q4k_lane u_lane1 (.clk(clk), .rst_n(rst_n), .start(start), .req(req1), .res(res1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      d_r     <= '0;
      dmin_r  <= '0;
      limit_r <= '0;
      pos_r   <= '0;
      sel_r   <= 1'b0;
      emit_r  <= '0;
      for (int j = 0; j < PairCount; j++) begin
        sc_r[j] <= '0;
        mn_r[j] <= '0;
      end
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (acc && in_operation == OP_HEADER) begin
            d_r     <= in_half_scale;
            dmin_r  <= in_half_min;
            limit_r <= (in_valid_count > 9'(BlockValues)) ? 9'(BlockValues) : in_valid_count;
            pos_r   <= '0;
            for (int j = 0; j < 4; j++) begin
              sc_r[j]   <= sb[j][5:0];
              mn_r[j]   <= sb[j+4][5:0];
              sc_r[j+4] <= {sb[j][7:6], sb[j+8][3:0]};
              mn_r[j+4] <= {sb[j+4][7:6], sb[j+8][7:4]};
            end
          end else if (acc && !pos_r[7]) begin
            pos_r <= pos_r + 8'd1;
            // chunk done: next pair of scale/min entries moves to the lanes
            if (pos_r[4:0] == 5'(ChunkLanes - 1)) begin
              for (int j = 0; j < PairCount; j++) begin
                sc_r[j] <= (j < PairCount - 2) ? sc_r[(j+2) % PairCount] : 6'd0;
                mn_r[j] <= (j < PairCount - 2) ? mn_r[(j+2) % PairCount] : 6'd0;
              end
            end
            if (start) begin
              emit_r  <= {e1, e0};
              sel_r   <= !e0;
              idx0_r  <= idx0;
              idx1_r  <= idx1;
              state_r <= ST_BUSY;
            end
          end
        end
        ST_BUSY: begin
          if (res0.done) begin
            res0_r  <= res0.bits;
            res1_r  <= res1.bits;
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            if (!sel_r && emit_r[1]) sel_r <= 1'b1;
            else state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = (state_r == ST_OUT);
  assign out_value_bits    = sel_r ? res1_r : res0_r;
  assign out_element_index = sel_r ? idx1_r : idx0_r;
  assign out_last_of_item  = sel_r || !emit_r[1];

endmodule

>>> rtl/q4k_lane.sv
// ----------------------------------------------------------------------------
// q4k_lane
// One dequant lane: d*sc*q - dmin*m with exact products, single RNE rounding.
// Five stages: min product, scale product, subtract, leading-one search, round.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module q4k_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  q4k_pkg::lane_req_t req,
  output q4k_pkg::lane_res_t res
);
  import q4k_pkg::*;

  // finite halves are held as integers in units of 2^-24
  logic [39:0] hd, hm;
  logic        d_inf, d_nan, m_inf, m_nan;

  always_comb begin
    hd = (req.d[14:10] == 5'd0) ? {30'd0, req.d[9:0]}
       : ({29'd0, 1'b1, req.d[9:0]} << (req.d[14:10] - 5'd1));
    hm = (req.dmin[14:10] == 5'd0) ? {30'd0, req.dmin[9:0]}
       : ({29'd0, 1'b1, req.dmin[9:0]} << (req.dmin[14:10] - 5'd1));
    d_inf = (req.d[14:10] == 5'h1F) && (req.d[9:0] == 10'd0);
    d_nan = (req.d[14:10] == 5'h1F) && (req.d[9:0] != 10'd0);
    m_inf = (req.dmin[14:10] == 5'h1F) && (req.dmin[9:0] == 10'd0);
    m_nan = (req.dmin[14:10] == 5'h1F) && (req.dmin[9:0] != 10'd0);
  end

  logic [4:0]  v_r;
  // stage 1
  logic [9:0]  scq_r;
  logic [39:0] hd_r;
  logic [45:0] pb1_r;
  logic        sd1_r, sm1_r, dinf_r, dnan_r, minf_r, mnan_r, mz_r;
  // stage 2
  logic [49:0] pa_r;
  logic [45:0] pb2_r;
  logic        sd2_r, sm2_r, an_r, ai_r, bn_r, bi_r;
  // stage 3
  logic [50:0] mag3_r;
  logic        sg3_r, nan3_r, inf3_r, isg3_r;
  // stage 4
  logic [50:0] mag4_r;
  logic [5:0]  p4_r;
  logic        sg4_r, nan4_r, inf4_r, isg4_r;
  logic [31:0] bits_r;

  logic signed [52:0] va, vb, diff;
  logic [5:0]  p_nxt;
  logic [50:0] norm;
  logic [23:0] mant;
  logic        rnd;
  logic [24:0] mant_rnd;
  logic [7:0]  ex;
  logic [31:0] bits_nxt;

  always_comb begin
    va   = sd2_r ? -$signed({3'b000, pa_r}) : $signed({3'b000, pa_r});
    vb   = sm2_r ? -$signed({7'd0, pb2_r}) : $signed({7'd0, pb2_r});
    diff = va - vb;
    p_nxt = 6'd0;
    for (int i = 0; i < 51; i++) begin
      if (mag3_r[i]) p_nxt = 6'(i);
    end
    norm     = mag4_r << (6'd50 - p4_r);
    mant     = norm[50:27];
    rnd      = norm[26] && ((|norm[25:0]) || mant[0]);
    mant_rnd = {1'b0, mant} + {24'd0, rnd};
    ex       = 8'(p4_r) + 8'd103 + {7'd0, mant_rnd[24]};
    if (nan4_r)
      bits_nxt = CANON_NAN;
    else if (inf4_r)
      bits_nxt = {isg4_r, 8'hFF, 23'd0};
    else if (mag4_r == 51'd0)
      bits_nxt = {sg4_r, 31'd0};
    else
      bits_nxt = {sg4_r, ex, mant_rnd[22:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], start};
    end
    scq_r  <= 10'(req.sc * req.q);
    hd_r   <= hd;
    pb1_r  <= 46'(hm * req.m);
    sd1_r  <= req.d[15];
    sm1_r  <= req.dmin[15];
    dinf_r <= d_inf;
    dnan_r <= d_nan;
    minf_r <= m_inf;
    mnan_r <= m_nan;
    mz_r   <= (req.m == 6'd0);

    pa_r  <= 50'(hd_r * scq_r);
    pb2_r <= pb1_r;
    sd2_r <= sd1_r;
    sm2_r <= sm1_r;
    an_r  <= dnan_r || (dinf_r && scq_r == 10'd0);
    ai_r  <= dinf_r && scq_r != 10'd0;
    bn_r  <= mnan_r || (minf_r && mz_r);
    bi_r  <= minf_r && !mz_r;

    mag3_r <= diff[52] ? 51'(-diff) : 51'(diff);
    // exact zero: negative only for -0 minus +0
    sg3_r  <= (diff == 53'sd0) ? ((pa_r == 50'd0 && pb2_r == 46'd0) && sd2_r && !sm2_r)
                               : diff[52];
    nan3_r <= an_r || bn_r || (ai_r && bi_r && (sd2_r == sm2_r));
    inf3_r <= ai_r || bi_r;
    isg3_r <= ai_r ? sd2_r : !sm2_r;

    mag4_r <= mag3_r;
    p4_r   <= p_nxt;
    sg4_r  <= sg3_r;
    nan4_r <= nan3_r;
    inf4_r <= inf3_r;
    isg4_r <= isg3_r;

    bits_r <= bits_nxt;
  end

  assign res.done = v_r[4];
  assign res.bits = bits_r;

endmodule

>>> rtl/q4k_checker.sv
// ----------------------------------------------------------------------------
// q4k_checker
// Port-level checks on the dequantizer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "q4k_superblock_dequantizer_unit_macros.svh"

module q4k_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value_bits,
  input logic        out_last_of_item
);
  logic stalled;
  logic first_taken;

  assign stalled     = out_valid && !out_ready && rst_n;
  assign first_taken = rst_n && out_valid && out_ready && !out_last_of_item;

  // a stalled result keeps its value
  `Q4K_ASSERT_IMPL(a_out_hold, clk, rst_n, $past(stalled), out_valid && $stable(out_value_bits))
  // one request in flight: no new request while a result is shown
  `Q4K_ASSERT_NEVER(a_no_overlap, clk, rst_n, in_ready && out_valid)
  // a non-final result is followed directly by the second one
  `Q4K_ASSERT_NEXT(a_pair_follows, clk, first_taken, out_valid || !rst_n)
  `Q4K_ASSERT_NEXT(a_reset_quiet, clk, !rst_n, !out_valid)
endmodule

bind q4k_superblock_dequantizer_unit q4k_checker u_q4k_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_value_bits(out_value_bits), .out_last_of_item(out_last_of_item)
);

>>> test/q4k_superblock_dequantizer_unit_test.sv
// ----------------------------------------------------------------------------
// q4k_superblock_dequantizer_unit_test
// Drives headers and quant bytes through the Q4_K dequantizer with random
// idling and back-pressure, predicts each float result and checks it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module q4k_superblock_dequantizer_unit_test;
  import q4k_pkg::*;

  typedef struct {
    logic [31:0] value_bits;
    logic [7:0]  element_index;
    logic        last_of_item;
  } dequant_value_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [15:0] in_half_scale;
  logic [15:0] in_half_min;
  logic [63:0] in_scale_bytes_low;
  logic [31:0] in_scale_bytes_high;
  logic [8:0]  in_valid_count;
  logic [7:0]  in_quant_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_value_bits;
  logic [7:0]  out_element_index;
  logic        out_last_of_item;

  q4k_superblock_dequantizer_unit uut (.*);

  // predictor copy of the block state
  logic [15:0] sb_scale;
  logic [15:0] sb_min;
  logic [7:0]  sb_packed [12];
  logic [8:0]  sb_limit;
  logic [7:0]  sb_byte_pos;

  dequant_value_t pending_values[$];
  int errors;
  int idle_cycles;
  int hold_cycles;
  int stall_left;
  bit no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic real half_to_real(logic [15:0] h);
    logic [63:0] bits;
    real v;
    if (h[14:10] == 5'd31) begin
      bits = (h[9:0] != 0) ? 64'h7FF8_0000_0000_0000 : 64'h7FF0_0000_0000_0000;
      bits[63] = h[15];
      return $bitstoreal(bits);
    end
    if (h[14:10] == 5'd0) begin
      v = h[9:0] * (2.0 ** -24);
      return h[15] ? -v : v;
    end
    bits = {h[15], 11'(h[14:10] - 15 + 1023), h[9:0], 42'd0};
    return $bitstoreal(bits);
  endfunction

  // double to single, round to nearest even; operands never reach the
  // single subnormal or overflow range, since every value is a multiple of 2^-24
  function automatic logic [31:0] real_to_single(real r);
    logic [63:0] bits;
    logic [31:0] res;
    logic        up;
    bits = $realtobits(r);
    if (bits[62:52] == 11'h7FF)
      return (bits[51:0] != 0) ? CANON_NAN : {bits[63], 8'hFF, 23'd0};
    if (bits[62:52] == 11'd0) return {bits[63], 31'd0};
    res = {bits[63], 8'(bits[62:52] - 1023 + 127), bits[51:29]};
    up = bits[28] && ((bits[27:0] != 0) || bits[29]);
    return res + 32'(up);
  endfunction

  function automatic logic [31:0] dequant_value(int pair, logic [3:0] q);
    logic [5:0] sc;
    logic [5:0] m;
    real ds;
    real dm;
    if (pair < 4) begin
      sc = sb_packed[pair][5:0];
      m  = sb_packed[pair + 4][5:0];
    end else begin
      sc = {sb_packed[pair - 4][7:6], sb_packed[pair + 4][3:0]};
      m  = {sb_packed[pair][7:6], sb_packed[pair + 4][7:4]};
    end
    ds = half_to_real(sb_scale) * sc;
    dm = half_to_real(sb_min) * m;
    return real_to_single(ds * q - dm);
  endfunction

  task automatic predict_request();
    int chunk;
    int lane;
    int idx;
    int n;
    dequant_value_t v;
    if (in_operation == OP_HEADER) begin
      sb_scale = in_half_scale;
      sb_min = in_half_min;
      for (int k = 0; k < 8; k++) sb_packed[k] = in_scale_bytes_low[8*k +: 8];
      for (int k = 0; k < 4; k++) sb_packed[8 + k] = in_scale_bytes_high[8*k +: 8];
      sb_limit = (in_valid_count > BlockValues) ? 9'(BlockValues) : in_valid_count;
      sb_byte_pos = 0;
    end else if (sb_byte_pos < BlockValues / 2) begin
      chunk = sb_byte_pos / ChunkLanes;
      lane = sb_byte_pos % ChunkLanes;
      sb_byte_pos = sb_byte_pos + 1;
      n = 0;
      for (int k = 0; k < 2; k++) begin
        idx = chunk * 64 + k * ChunkLanes + lane;
        if (idx < sb_limit) begin
          v.value_bits = dequant_value(2 * chunk + k, in_quant_byte[4*k +: 4]);
          v.element_index = 8'(idx);
          v.last_of_item = 1'b0;
          pending_values.push_back(v);
          n++;
        end
      end
      if (n > 0) pending_values[$].last_of_item = 1'b1;
    end
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) predict_request();
  end

  always @(posedge clk) begin
    dequant_value_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_values.size() == 0) begin
        report_mismatch($sformatf("unexpected value idx %0d", out_element_index));
      end else begin
        e = pending_values.pop_front();
        if (out_value_bits !== e.value_bits)
          report_mismatch($sformatf("idx %0d value %h, want %h", e.element_index,
                                    out_value_bits, e.value_bits));
        if (out_element_index !== e.element_index)
          report_mismatch($sformatf("index %0d, want %0d", out_element_index,
                                    e.element_index));
        if (out_last_of_item !== e.last_of_item)
          report_mismatch($sformatf("idx %0d last %b, want %b", e.element_index,
                                    out_last_of_item, e.last_of_item));
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_gap();
      end
    end
  end

  // watchdog: cycles without any handshake
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 5000) begin
        $display("timeout at %0t", $time);
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_item(logic op, logic [15:0] hs, logic [15:0] hm, logic [63:0] lo,
                           logic [31:0] hi, logic [8:0] cnt, logic [7:0] qb);
    int gap;
    in_valid <= 1'b1;
    in_operation <= op;
    in_half_scale <= hs;
    in_half_min <= hm;
    in_scale_bytes_low <= lo;
    in_scale_bytes_high <= hi;
    in_valid_count <= cnt;
    in_quant_byte <= qb;
    do @(posedge clk); while (!in_ready);
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_header(logic [15:0] hs, logic [15:0] hm, logic [63:0] lo,
                             logic [31:0] hi, logic [8:0] cnt);
    send_item(OP_HEADER, hs, hm, lo, hi, cnt, 8'($urandom));
  endtask

  task automatic send_byte(logic [7:0] qb);
    send_item(OP_DATA, 16'($urandom), 16'($urandom), {$urandom, $urandom}, $urandom,
              9'($urandom), qb);
  endtask

  function automatic logic [15:0] random_half();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return {1'($urandom), 5'($urandom_range(5, 20)), 10'($urandom)};
    return 16'($urandom);
  endfunction

  task automatic send_block(int n_bytes, logic [8:0] cnt);
    send_header(random_half(), random_half(), {$urandom, $urandom}, $urandom, cnt);
    repeat (n_bytes) send_byte(8'($urandom));
  endtask

  task automatic drain();
    // last request may have left valid high
    in_valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_data_before_header();
    send_byte(8'hFF);
    send_byte(8'h5A);
    drain();
  endtask

  task automatic test_directed_cases();
    // unit scales, all scale bits set, nibble extremes
    send_header(16'h3C00, 16'h3C00, '1, '1, 9'd256);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h0F);
    // count of one: only the low nibble of byte 0
    send_header(16'hBC00, 16'h0001, 64'h0123_4567_89AB_CDEF, 32'hC0F0_3F0F, 9'd1);
    send_byte(8'hF7);
    send_byte(8'h33);
    // count zero
    send_header(16'h3C00, 16'h3C00, '1, '1, 9'd0);
    send_byte(8'hFF);
    // count above block size is clamped
    send_header(16'h7BFF, 16'h8400, {8{8'hC5}}, 32'h9A9A_9A9A, 9'd511);
    send_byte(8'hA5);
    // infinity times zero in the scale and the min product
    send_header(16'h7C00, 16'hFC00, 64'h0000_0000_3F3F_3F00, 32'h0, 9'd256);
    send_byte(8'h10);
    send_byte(8'h11);
    // NaN scale, subnormal and negative zero halves
    send_header(16'h7E01, 16'h03FF, '1, '1, 9'd256);
    send_byte(8'h81);
    send_header(16'h8000, 16'h8000, '1, '1, 9'd40);
    send_byte(8'h00);
    send_byte(8'h9C);
    drain();
  endtask

  task automatic test_random_blocks();
    int sent;
    int n_bytes;
    int r;
    logic [8:0] cnt;
    sent = 0;
    while (sent < 900) begin
      no_idle = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 9);
      if (r < 6) n_bytes = 128;
      else if (r < 8) n_bytes = $urandom_range(0, 127);
      else n_bytes = $urandom_range(129, 134);
      r = $urandom_range(0, 9);
      if (r < 5) cnt = 9'd256;
      else cnt = 9'($urandom_range(0, 511));
      send_block(n_bytes, cnt);
      sent += n_bytes + 1;
    end
    no_idle = 1'b0;
    drain();
  endtask

  task automatic test_output_backpressure();
    hold_cycles = 300;
    no_idle = 1'b1;
    send_block(64, 9'd256);
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    errors = 0;
    hold_cycles = 0;
    no_idle = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= OP_HEADER;
    in_half_scale <= '0;
    in_half_min <= '0;
    in_scale_bytes_low <= '0;
    in_scale_bytes_high <= '0;
    in_valid_count <= '0;
    in_quant_byte <= '0;
    sb_scale = '0;
    sb_min = '0;
    for (int k = 0; k < 12; k++) sb_packed[k] = '0;
    sb_limit = '0;
    sb_byte_pos = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_data_before_header();
    test_directed_cases();
    test_output_backpressure();
    test_random_blocks();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
